// ----- rtl/vector_reflect_refract_defines.svh -----
// Assertion macros shared by the checker of the reflect/refract block.
// Every assertion samples on clk and is switched off while rst_n is low.
`ifndef VECTOR_REFLECT_REFRACT_DEFINES_SVH
`define VECTOR_REFLECT_REFRACT_DEFINES_SVH

// An implication that must hold at every clock edge outside reset.
`define VRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define VRR_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cond) else $error(msg);

`endif

// ----- rtl/vrr_pkg.sv -----
// Shared types, constants and rounding helper of the reflect/refract block.
// No dependencies.
package vrr_pkg;

    typedef logic [3:0][31:0] vec4_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_TIR  = 2'd2
    } status_t;

    localparam int FRAC_BITS_DEF = 16;
    localparam logic signed [63:0] ONE30 = 64'sh0000_0000_4000_0000;

    // Shift right by 30 with round half away from zero.
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
        logic [63:0] m;
        m = x[63] ? 64'(-x) : 64'(x);
        m = (m + 64'h0000_0000_2000_0000) >> 30;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ----- rtl/vrr_delay.sv -----
// Enabled shift line that carries payload alongside the pipeline stages.
// Depends on nothing.
module vrr_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int k = 1; k < N; k++)
            begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    assign q = pipe_reg[N-1];

endmodule

// ----- rtl/vrr_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// Requires num >> Q_W to be below den. Depends on nothing.
module vrr_div #(
    parameter int NUM_W = 61,
    parameter int DEN_W = 31,
    parameter int Q_W   = 31
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];

    logic [DEN_W-1:0] rem_in  [Q_W];
    logic [Q_W-1:0]   low_in  [Q_W];
    logic [Q_W-1:0]   quo_in  [Q_W];
    logic [DEN_W-1:0] den_in  [Q_W];
    logic [DEN_W:0]   shifted [Q_W];
    logic [DEN_W:0]   diff    [Q_W];

    always_comb
    begin
        rem_in[0] = DEN_W'(num[NUM_W-1:Q_W]);
        low_in[0] = num[Q_W-1:0];
        quo_in[0] = '0;
        den_in[0] = den;
        for (int k = 1; k < Q_W; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            low_in[k] = low_reg[k-1];
            quo_in[k] = quo_reg[k-1];
            den_in[k] = den_reg[k-1];
        end
        for (int k = 0; k < Q_W; k++)
        begin
            shifted[k] = {rem_in[k], low_in[k][Q_W-1]};
            diff[k]    = shifted[k] - {1'b0, den_in[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                rem_reg[k] <= diff[k][DEN_W] ? shifted[k][DEN_W-1:0] : diff[k][DEN_W-1:0];
                quo_reg[k] <= {quo_in[k][Q_W-2:0], ~diff[k][DEN_W]};
                low_reg[k] <= {low_in[k][Q_W-2:0], 1'b0};
                den_reg[k] <= den_in[k];
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

// ----- rtl/vrr_sqrt.sv -----
// Pipelined integer square root (floor), one root bit per stage.
// Depends on nothing.
module vrr_sqrt #(
    parameter int IN_W = 62
) (
    input  logic                clk,
    input  logic                en,
    input  logic [IN_W-1:0]     radicand,
    output logic [IN_W/2-1:0]   root
);

    localparam int OUT_W = IN_W / 2;

    logic [OUT_W+1:0] rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [IN_W-1:0]  low_reg  [OUT_W];

    logic [OUT_W+1:0] rem_in  [OUT_W];
    logic [OUT_W-1:0] root_in [OUT_W];
    logic [IN_W-1:0]  low_in  [OUT_W];
    logic [OUT_W+3:0] trial   [OUT_W];
    logic [OUT_W+3:0] cmp     [OUT_W];
    logic             ge      [OUT_W];

    always_comb
    begin
        rem_in[0]  = '0;
        root_in[0] = '0;
        low_in[0]  = radicand;
        for (int k = 1; k < OUT_W; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
            low_in[k]  = low_reg[k-1];
        end
        for (int k = 0; k < OUT_W; k++)
        begin
            trial[k] = {rem_in[k], low_in[k][IN_W-1:IN_W-2]};
            cmp[k]   = {2'b00, root_in[k], 2'b01};
            ge[k]    = trial[k] >= cmp[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < OUT_W; k++)
            begin
                rem_reg[k]  <= ge[k] ? (OUT_W+2)'(trial[k] - cmp[k]) : (OUT_W+2)'(trial[k]);
                root_reg[k] <= {root_in[k][OUT_W-2:0], ge[k]};
                low_reg[k]  <= {low_in[k][IN_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[OUT_W-1];

endmodule

// ----- rtl/vrr_unit.sv -----
// Normalizes a four-component Q16.16 vector to a Q.30 unit vector in 69 stages.
// Depends on vrr_pkg, vrr_delay, vrr_sqrt and vrr_div.
module vrr_unit
    import vrr_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  vec4_t vec,
    output vec4_t unit,
    output logic  zero
);

    logic [3:0][31:0] mag_a_reg, mag_b_reg;
    logic [3:0]       neg_a_reg, neg_b_reg;
    logic [31:0]      top_b_next, top_b_reg;
    logic [3:0][29:0] m_c_next, m_c_reg, m_dl;
    logic [4:0]       flags_c_reg, flags_dl;
    logic [3:0][59:0] sq_d_reg;
    logic [61:0]      sum_e_reg;
    logic [30:0]      len;
    logic [30:0]      len_f_reg;
    logic [3:0][60:0] num_f_reg;
    logic [30:0]      quo [4];
    vec4_t            unit_reg;
    logic             zero_reg;
    logic [4:0]       msb;
    logic [4:0]       lsh;
    logic [1:0]       rsh;
    logic [31:0]      top_ab, top_cd;

    // Scale so the largest magnitude lands in [2^28, 2^30).
    always_comb
    begin
        top_ab     = (mag_a_reg[0] > mag_a_reg[1]) ? mag_a_reg[0] : mag_a_reg[1];
        top_cd     = (mag_a_reg[2] > mag_a_reg[3]) ? mag_a_reg[2] : mag_a_reg[3];
        top_b_next = (top_ab > top_cd) ? top_ab : top_cd;
        msb = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (top_b_reg[i])
            begin
                msb = 5'(i);
            end
        end
        lsh = (msb < 5'd28) ? 5'(5'd28 - msb) : 5'd0;
        rsh = top_b_reg[31] ? 2'd2 : (top_b_reg[30] ? 2'd1 : 2'd0);
        for (int i = 0; i < 4; i++)
        begin
            m_c_next[i] = 30'((mag_b_reg[i] << lsh) >> rsh);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag_a_reg[i] <= vec[i][31] ? 32'(-vec[i]) : vec[i];
                neg_a_reg[i] <= vec[i][31];
                sq_d_reg[i]  <= m_c_reg[i] * m_c_reg[i];
                num_f_reg[i] <= {m_dl[i], 30'b0} + 61'(len >> 1);
            end
            mag_b_reg   <= mag_a_reg;
            neg_b_reg   <= neg_a_reg;
            top_b_reg   <= top_b_next;
            m_c_reg     <= m_c_next;
            flags_c_reg <= {top_b_reg == 32'd0, neg_b_reg};
            sum_e_reg   <= 62'(sq_d_reg[0]) + 62'(sq_d_reg[1])
                         + 62'(sq_d_reg[2]) + 62'(sq_d_reg[3]);
            len_f_reg   <= len;
        end
    end

    vrr_sqrt #(.IN_W(62)) u_len (
        .clk      (clk),
        .en       (en),
        .radicand (sum_e_reg),
        .root     (len)
    );

    vrr_delay #(.W(120), .N(33)) u_m_dl (
        .clk (clk),
        .en  (en),
        .d   (m_c_reg),
        .q   (m_dl)
    );

    vrr_delay #(.W(5), .N(65)) u_flags_dl (
        .clk (clk),
        .en  (en),
        .d   (flags_c_reg),
        .q   (flags_dl)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        vrr_div #(.NUM_W(61), .DEN_W(31), .Q_W(31)) u_div (
            .clk (clk),
            .en  (en),
            .num (num_f_reg[i]),
            .den (len_f_reg),
            .quo (quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (quo[i] > 31'h4000_0000)
                begin
                    unit_reg[i] <= flags_dl[i] ? 32'hC000_0000 : 32'h4000_0000;
                end
                else
                begin
                    unit_reg[i] <= flags_dl[i] ? 32'(-{1'b0, quo[i]}) : {1'b0, quo[i]};
                end
            end
            zero_reg <= flags_dl[4];
        end
    end

    assign unit = unit_reg;
    assign zero = zero_reg;

endmodule

// ----- rtl/vector_reflect_refract.sv -----
// Reflection and refraction of a four-component Q16.16 vector about a normal.
// One beat enters per cycle; the whole pipeline holds while a result waits on out_ready.
// The critical spans are the two 31-stage square roots and the 31- and 48-stage dividers.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
module vector_reflect_refract
    import vrr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] inc_x,
    input  logic [31:0] inc_y,
    input  logic [31:0] inc_z,
    input  logic [31:0] inc_w,
    input  logic [31:0] nrm_x,
    input  logic [31:0] nrm_y,
    input  logic [31:0] nrm_z,
    input  logic [31:0] nrm_w,
    input  logic [15:0] index_from,
    input  logic [15:0] index_to,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [31:0] out_w,
    output logic [1:0]  status
);

    localparam int LAT = 143;
    localparam int SH  = 30 - FRAC_BITS;
    localparam logic [63:0] HALF = (64'd1 << SH) >> 1;

    logic           en;
    logic [LAT-1:0] valid_reg;

    vec4_t       inc_vec, nrm_vec, u69, n69, u73, n72, n139;
    logic        zi69, zn69, zero142;
    logic [15:0] n2_fix, n1_72, n2_72, n1_74, n2_75;
    logic        cmd141, cmd142_reg;

    logic [3:0][63:0] pr_reg, p_reg, sn_reg, r_reg;
    logic [63:0]      sum_reg, dd_reg;
    logic [31:0]      d_reg;
    logic [31:0]      n1sq_73_reg, n1sq_74_reg;
    logic [31:0]      n2sq_73_reg, n2sq_74_reg, n2sq_75_reg, n2sq_76_reg, n2sq_77_reg;
    logic [3:0][33:0] refl_reg, a_reg, refl141;
    logic [30:0]      c_reg;
    logic [61:0]      prodc_reg, numq_reg, numqd_reg;
    logic [62:0]      lim_reg;
    logic [3:0][50:0] x_reg;
    logic [3:0][48:0] numa_reg, ra_reg, ra140;
    logic [3:0]       nega_reg, nega124;
    logic [15:0]      n2_76_reg;
    logic             tir_reg, tir142;
    logic [30:0]      q108, s139;
    logic [47:0]      quoa [4];
    logic [61:0]      radicand;
    logic [3:0][63:0] y_reg;
    logic [3:0][31:0] out_reg;
    logic [1:0]       status_reg;

    logic [3:0][33:0] refl_next, a_next;
    logic [3:0][48:0] numa_next;
    logic [3:0][63:0] y_next;
    logic [3:0][31:0] out_next;
    logic [31:0]      d_next;
    logic [1:0]       status_next;
    logic signed [63:0] dr, uw, sel, pw;
    logic [63:0]        ymag;
    logic [50:0]        xmag;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign inc_vec  = {inc_w, inc_z, inc_y, inc_x};
    assign nrm_vec  = {nrm_w, nrm_z, nrm_y, nrm_x};
    assign n2_fix   = (index_to == 16'd0) ? 16'd1 : index_to;
    assign radicand = {1'b0, 31'(31'h4000_0000 - q108), 30'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[LAT-1];

    vrr_unit u_inc (.clk(clk), .en(en), .vec(inc_vec), .unit(u69), .zero(zi69));
    vrr_unit u_nrm (.clk(clk), .en(en), .vec(nrm_vec), .unit(n69), .zero(zn69));

    vrr_delay #(.W(128), .N(4))   u_u73   (.clk(clk), .en(en), .d(u69), .q(u73));
    vrr_delay #(.W(128), .N(3))   u_n72   (.clk(clk), .en(en), .d(n69), .q(n72));
    vrr_delay #(.W(128), .N(70))  u_n139  (.clk(clk), .en(en), .d(n69), .q(n139));
    vrr_delay #(.W(1),   .N(73))  u_zero  (.clk(clk), .en(en), .d(zi69 | zn69), .q(zero142));
    vrr_delay #(.W(1),   .N(141)) u_cmd   (.clk(clk), .en(en), .d(command), .q(cmd141));
    vrr_delay #(.W(16),  .N(72))  u_n1_72 (.clk(clk), .en(en), .d(index_from), .q(n1_72));
    vrr_delay #(.W(16),  .N(74))  u_n1_74 (.clk(clk), .en(en), .d(index_from), .q(n1_74));
    vrr_delay #(.W(16),  .N(72))  u_n2_72 (.clk(clk), .en(en), .d(n2_fix), .q(n2_72));
    vrr_delay #(.W(16),  .N(75))  u_n2_75 (.clk(clk), .en(en), .d(n2_fix), .q(n2_75));
    vrr_delay #(.W(136), .N(67))  u_refl  (.clk(clk), .en(en), .d(refl_reg), .q(refl141));
    vrr_delay #(.W(1),   .N(65))  u_tir   (.clk(clk), .en(en), .d(tir_reg), .q(tir142));
    vrr_delay #(.W(4),   .N(48))  u_nega  (.clk(clk), .en(en), .d(nega_reg), .q(nega124));
    vrr_delay #(.W(196), .N(15))  u_ra    (.clk(clk), .en(en), .d(ra_reg), .q(ra140));

    // Root argument scale: q is divided out of r^2 (1 - d^2) in Q.30.
    vrr_div #(.NUM_W(62), .DEN_W(32), .Q_W(31)) u_divq (
        .clk (clk),
        .en  (en),
        .num (numqd_reg),
        .den (n2sq_77_reg),
        .quo (q108)
    );

    vrr_sqrt #(.IN_W(62)) u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (radicand),
        .root     (s139)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_diva
        vrr_div #(.NUM_W(49), .DEN_W(16), .Q_W(48)) u_diva (
            .clk (clk),
            .en  (en),
            .num (numa_reg[i]),
            .den (n2_76_reg),
            .quo (quoa[i])
        );
    end

    always_comb
    begin
        dr = rnd30($signed(sum_reg));
        if (dr > ONE30)
        begin
            d_next = 32'(ONE30);
        end
        else if (dr < -ONE30)
        begin
            d_next = 32'(-ONE30);
        end
        else
        begin
            d_next = 32'(dr);
        end

        for (int i = 0; i < 4; i++)
        begin
            uw = 64'($signed(u73[i])) <<< 30;
            pw = $signed(p_reg[i]);
            refl_next[i] = 34'(rnd30((pw <<< 1) - uw));
            a_next[i]    = 34'(rnd30(pw - uw));

            xmag = x_reg[i][50] ? 51'(-x_reg[i]) : x_reg[i];
            numa_next[i] = 49'(xmag) + 49'(n2_75 >> 1);

            sel = cmd141 ? $signed(r_reg[i]) : 64'($signed(refl141[i]));
            ymag = sel[63] ? 64'(-sel) : 64'(sel);
            ymag = (ymag + HALF) >> SH;
            y_next[i] = sel[63] ? 64'(-ymag) : ymag;

            if ($signed(y_reg[i]) > 64'sd2147483647)
            begin
                out_next[i] = 32'h7FFF_FFFF;
            end
            else if ($signed(y_reg[i]) < -64'sd2147483648)
            begin
                out_next[i] = 32'h8000_0000;
            end
            else
            begin
                out_next[i] = y_reg[i][31:0];
            end
        end

        status_next = ST_OK;
        if (zero142)
        begin
            status_next = ST_ZERO;
        end
        else if (cmd142_reg && tir142)
        begin
            status_next = ST_TIR;
        end
        if (status_next != ST_OK)
        begin
            out_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pr_reg[i]   <= $signed(u69[i]) * $signed(n69[i]);
                p_reg[i]    <= $signed(d_reg) * $signed(n72[i]);
                x_reg[i]    <= $signed(a_reg[i]) * $signed({1'b0, n1_74});
                nega_reg[i] <= x_reg[i][50];
                ra_reg[i]   <= nega124[i] ? 49'(-{1'b0, quoa[i]}) : {1'b0, quoa[i]};
                sn_reg[i]   <= $signed({1'b0, s139}) * $signed(n139[i]);
                r_reg[i]    <= 64'($signed(ra140[i])) - rnd30($signed(sn_reg[i]));
            end
            sum_reg     <= $signed(pr_reg[0]) + $signed(pr_reg[1])
                         + $signed(pr_reg[2]) + $signed(pr_reg[3]);
            d_reg       <= d_next;
            dd_reg      <= $signed(d_reg) * $signed(d_reg);
            n1sq_73_reg <= n1_72 * n1_72;
            n2sq_73_reg <= n2_72 * n2_72;
            refl_reg    <= refl_next;
            a_reg       <= a_next;
            c_reg       <= 31'(ONE30 - rnd30($signed(dd_reg)));
            n1sq_74_reg <= n1sq_73_reg;
            n2sq_74_reg <= n2sq_73_reg;
            prodc_reg   <= n1sq_74_reg * c_reg;
            n2sq_75_reg <= n2sq_74_reg;
            numq_reg    <= prodc_reg + 62'(n2sq_75_reg >> 1);
            lim_reg     <= 63'({n2sq_75_reg, 30'b0}) + 63'(n2sq_75_reg);
            numa_reg    <= numa_next;
            n2_76_reg   <= n2_75;
            n2sq_76_reg <= n2sq_75_reg;
            // Beyond this limit the quotient exceeds one: total internal reflection.
            tir_reg     <= {1'b0, numq_reg} >= lim_reg;
            numqd_reg   <= ({1'b0, numq_reg} >= lim_reg) ? 62'd0 : numq_reg;
            n2sq_77_reg <= n2sq_76_reg;
            cmd142_reg  <= cmd141;
            y_reg       <= y_next;
            out_reg     <= out_next;
            status_reg  <= status_next;
        end
    end

    assign out_x  = out_reg[0];
    assign out_y  = out_reg[1];
    assign out_z  = out_reg[2];
    assign out_w  = out_reg[3];
    assign status = status_reg;

endmodule

// ----- rtl/vrr_checker.sv -----
// Port-level checks of the reflect/refract block, bound to its top level.
// Depends on vrr_pkg and the assertion macros header.
`include "vector_reflect_refract_defines.svh"

module vrr_port_checker
    import vrr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_z,
    input logic [31:0] out_w,
    input logic [1:0]  status
);

    // A stalled result beat must not vanish, nor may its out_x or status change.
    `VRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
    `VRR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_x) && $stable(status), "result beat changed")

    // The pipeline holds as a whole, so no beat may enter during an output stall.
    `VRR_ASSERT(a_stall_in, out_valid && !out_ready |-> !in_ready, "input taken during stall")

    // Any flagged result carries a zero vector.
    `VRR_ASSERT(a_flag_zero, out_valid && status != ST_OK |-> {out_x, out_y, out_z, out_w} == '0, "flagged result not zero")

endmodule

bind vector_reflect_refract vrr_port_checker u_vrr_checker (.*);

// ----- sim/vrr_checker.sv -----
`timescale 1ns / 1ps
// Checker for the reflect/refract block: watches both channels, predicts each
// result from the accepted input beat and compares it. Depends on vrr_pkg.
module vrr_checker
    import vrr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        command,
    input  logic [31:0] inc_x,
    input  logic [31:0] inc_y,
    input  logic [31:0] inc_z,
    input  logic [31:0] inc_w,
    input  logic [31:0] nrm_x,
    input  logic [31:0] nrm_y,
    input  logic [31:0] nrm_z,
    input  logic [31:0] nrm_w,
    input  logic [15:0] index_from,
    input  logic [15:0] index_to,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_x,
    input  logic [31:0] out_y,
    input  logic [31:0] out_z,
    input  logic [31:0] out_w,
    input  logic [1:0]  status,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [31:0] comp[4];
        status_t     st;
    } vec_result_t;

    vec_result_t expected_q[$];

    function automatic logic [63:0] mag(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] shr_round(input logic signed [63:0] x, input int k);
        logic [63:0] m;
        if (k == 0)
            return x;
        m = (mag(x) + (64'd1 << (k - 1))) >> k;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] root(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Scales a vector to unit length in Q.30; returns 0 for a zero vector.
    function automatic bit to_unit(input logic signed [63:0] v[4],
                                   output logic signed [63:0] u[4]);
        logic [63:0] m[4];
        logic [63:0] top, sum, len, q;
        top = 0;
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = mag(v[i]);
            if (m[i] > top)
                top = m[i];
        end
        if (top == 0)
            return 0;
        while (top >= (64'd1 << 30))
        begin
            top = top >> 1;
            for (int i = 0; i < 4; i++)
                m[i] = m[i] >> 1;
        end
        while (top < (64'd1 << 28))
        begin
            top = top << 1;
            for (int i = 0; i < 4; i++)
                m[i] = m[i] << 1;
        end
        for (int i = 0; i < 4; i++)
            sum = sum + m[i] * m[i];
        len = root(sum);
        for (int i = 0; i < 4; i++)
        begin
            q = ((m[i] << 30) + len / 2) / len;
            if (q > 64'd1 << 30)
                q = 64'd1 << 30;
            u[i] = v[i][63] ? -$signed(q) : $signed(q);
        end
        return 1;
    endfunction

    function automatic logic [31:0] saturate_out(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = shr_round(x, 30 - FRAC_BITS);
        if (y > 64'sd2147483647)
            y = 64'sd2147483647;
        if (y < -64'sd2147483648)
            y = -64'sd2147483648;
        return y[31:0];
    endfunction

    function automatic vec_result_t bend_ray(input logic cmd,
                                             input logic [31:0] iw[4],
                                             input logic [31:0] nw[4],
                                             input logic [15:0] n1w,
                                             input logic [15:0] n2w);
        vec_result_t r;
        logic signed [63:0] iv[4], nv[4], u[4], n[4], comp[4];
        logic signed [63:0] d, a, ra;
        logic [63:0] n1, n2, n2sq, c, q, s;
        for (int i = 0; i < 4; i++)
        begin
            iv[i] = $signed(iw[i]);
            nv[i] = $signed(nw[i]);
            r.comp[i] = '0;
        end
        n1 = n1w;
        n2 = (n2w == 0) ? 64'd1 : 64'(n2w);
        r.st = ST_ZERO;
        if (!to_unit(iv, u) || !to_unit(nv, n))
            return r;
        d = 0;
        for (int i = 0; i < 4; i++)
            d = d + u[i] * n[i];
        d = shr_round(d, 30);
        if (d > ONE30)
            d = ONE30;
        if (d < -ONE30)
            d = -ONE30;
        if (cmd == 1'b0)
        begin
            for (int i = 0; i < 4; i++)
                comp[i] = shr_round(2 * d * n[i] - u[i] * ONE30, 30);
        end
        else
        begin
            c = ONE30 - shr_round(d * d, 30);
            n2sq = n2 * n2;
            q = (n1 * n1 * c + n2sq / 2) / n2sq;
            if (q > ONE30)
            begin
                r.st = ST_TIR;
                return r;
            end
            s = root((ONE30 - q) << 30);
            for (int i = 0; i < 4; i++)
            begin
                a = shr_round(d * n[i] - u[i] * ONE30, 30);
                ra = $signed((mag(a * $signed(n1)) + n2 / 2) / n2);
                if (a[63])
                    ra = -ra;
                comp[i] = ra - shr_round($signed(s) * n[i], 30);
            end
        end
        for (int i = 0; i < 4; i++)
            r.comp[i] = saturate_out(comp[i]);
        r.st = ST_OK;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        vec_result_t e;
        if (rst_n && in_valid && in_ready)
            expected_q.push_back(bend_ray(command, '{inc_x, inc_y, inc_z, inc_w},
                                          '{nrm_x, nrm_y, nrm_z, nrm_w},
                                          index_from, index_to));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result beat with no input waiting");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                compare_field("out_x", e.comp[0], out_x);
                compare_field("out_y", e.comp[1], out_y);
                compare_field("out_z", e.comp[2], out_z);
                compare_field("out_w", e.comp[3], out_w);
                compare_field("status", 32'(e.st), 32'(status));
            end
        end
        pending = expected_q.size();
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Top of the reflect/refract testbench: clock, reset, stimulus and verdict.
// Depends on vrr_pkg, vector_reflect_refract and vrr_checker.
module tb;
    import vrr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [31:0] inc_x, inc_y, inc_z, inc_w;
    logic [31:0] nrm_x, nrm_y, nrm_z, nrm_w;
    logic [15:0] index_from, index_to;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_x, out_y, out_z, out_w;
    logic [1:0]  status;
    int          errors;
    int          pending;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;

    vector_reflect_refract i_dut (.*);

    vrr_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Receiver: random stalls, or a long hold-off while hold_off is set.
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(131072)) - 65536);
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Drives one beat and holds it until the block takes it.
    task automatic send_beat(input logic cmd, input logic [31:0] iv[4],
                             input logic [31:0] nv[4], input logic [15:0] n1,
                             input logic [15:0] n2);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        {inc_x, inc_y, inc_z, inc_w} <= {iv[0], iv[1], iv[2], iv[3]};
        {nrm_x, nrm_y, nrm_z, nrm_w} <= {nv[0], nv[1], nv[2], nv[3]};
        index_from <= n1;
        index_to <= n2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        logic [31:0] iv[4], nv[4];
        logic [15:0] n1, n2;
        for (int k = 0; k < count; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                iv[i] = rand_comp();
                nv[i] = rand_comp();
            end
            if ($urandom_range(19) == 0)
                iv = '{0, 0, 0, 0};
            if ($urandom_range(19) == 0)
                nv = '{0, 0, 0, 0};
            // Mostly realistic indices near 1.0 to 2.5, some anywhere.
            n1 = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(10240, 4096));
            n2 = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(10240, 4096));
            send_beat(1'($urandom_range(1)), iv, nv, n1, n2);
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (160) @(negedge clk);
    endtask

    initial
    begin
        in_valid = 1'b0;
        command = 1'b0;
        {inc_x, inc_y, inc_z, inc_w} = '0;
        {nrm_x, nrm_y, nrm_z, nrm_w} = '0;
        index_from = 16'd4096;
        index_to = 16'd4096;
        out_ready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, zero vectors, both commands, odd indices.
        send_beat(1'b0, '{32'h0001_0000, 0, 0, 0}, '{0, 32'h0001_0000, 0, 0}, 16'd4096, 16'd4096);
        send_beat(1'b0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                  '{32'h7fff_ffff, 0, 0, 32'h8000_0000}, 16'd0, 16'd0);
        send_beat(1'b1, '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
                  '{32'hffff_ffff, 32'h0000_0001, 0, 0}, 16'hffff, 16'hffff);
        send_beat(1'b0, '{0, 0, 0, 0}, '{1, 0, 0, 0}, 16'd4096, 16'd4096);
        send_beat(1'b1, '{1, 0, 0, 0}, '{0, 0, 0, 0}, 16'd4096, 16'd4096);
        send_beat(1'b1, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 16'd4096, 16'd4096);
        send_beat(1'b1, '{32'h0001_0000, 32'h0001_0000, 0, 0}, '{0, 32'h0001_0000, 0, 0},
                  16'd6144, 16'd4096);
        send_beat(1'b1, '{32'h0001_0000, 32'h0000_1000, 0, 0}, '{0, 32'hffff_0000, 0, 0},
                  16'd10000, 16'd4096);
        send_beat(1'b1, '{32'h0001_0000, 32'h0001_0000, 0, 0}, '{0, 32'h0001_0000, 0, 0},
                  16'd4096, 16'd6144);
        send_beat(1'b1, '{1, 2, 3, 4}, '{0, 0, 32'h0001_0000, 0}, 16'd4096, 16'd0);
        send_beat(1'b1, '{1, 2, 3, 4}, '{0, 0, 32'h0001_0000, 0}, 16'd0, 16'd4096);
        send_beat(1'b1, '{32'h0000_0001, 0, 0, 0}, '{32'hffff_ffff, 0, 0, 0}, 16'd1, 16'hffff);
        send_beat(1'b0, '{32'h0003_0000, 32'hfffc_0000, 0, 32'h0000_8000},
                  '{0, 0, 32'h8000_0000, 0}, 16'hffff, 16'd1);
        in_valid <= 1'b0;

        // Sender pauses until everything has come back.
        drain();

        // Long receiver hold-off while the sender keeps offering beats.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            send_random(200);
        join
        drain();

        send_idle_pct = 68;
        send_random(80);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        send_random(80);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        send_random(80);
        recv_stall_pct = 0;
        drain();

        if (errors == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vrr_pkg.sv
rtl/vrr_delay.sv
rtl/vrr_div.sv
rtl/vrr_sqrt.sv
rtl/vrr_unit.sv
rtl/vector_reflect_refract.sv
rtl/vrr_checker.sv
sim/vrr_checker.sv
sim/tb.sv
